// ===== hdl/fwtd_pkg.sv =====
// fwtd_pkg: shared types and constants for the flux weak-track detector
// holds the transaction structs, the opcode codes and the reference store sizing
// no dependencies
package fwtd_pkg;

   // reference store sizing
   localparam int MAX_FLUX_PER_REV = 131072;
   localparam int FLUX_ADDR_W      = $clog2(MAX_FLUX_PER_REV);

   // field widths
   localparam int INTERVAL_W = 24;
   localparam int TOL_W      = 16;
   localparam int COUNT_W    = 32;
   localparam int REV_W      = 8;

   localparam logic [TOL_W-1:0] DEFAULT_TOLERANCE = 16'd75;

   typedef enum logic [1:0] {
      OP_SAMPLE    = 2'd0,
      OP_END_REV   = 2'd1,
      OP_END_TRACK = 2'd2,
      OP_END_IMAGE = 2'd3
   } opcode_type;

   // input transaction
   typedef struct packed {
      opcode_type            opcode;
      logic [INTERVAL_W-1:0] flux_interval;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [7:0]         track_total;
      logic [7:0]         most_revolutions;
      logic               multi_revolution;
      logic [COUNT_W-1:0] transition_total;
      logic [7:0]         weak_tracks;
      logic               any_weak;
      logic               status;
   } rsp_type;

   // item handed from the sequencing stage to the compare stage
   typedef struct packed {
      opcode_type            opcode;
      logic [INTERVAL_W-1:0] flux_interval;
      logic [REV_W-1:0]      rev_count;
      logic                  rev_nonzero;
      logic [COUNT_W-1:0]    sample_count;
      logic                  len_diff;
      logic                  cmp_en;
      logic                  over_cap;
   } stage_type;

endpackage

// ===== hdl/flux_weak_track_detector_core.sv =====
// flux_weak_track_detector_core: top level of the multi-revolution weak-track detector
// connects the sequencing stage with its reference store and the compare stage
// depends on fwtd_pkg, fwtd_front, fwtd_back
//
//   port group   dir   handshake              payload
//   req_*        in    req_valid/req_ready    fwtd_pkg::req_type (opcode, flux_interval)
//   rsp_*        out   rsp_valid/rsp_ready    fwtd_pkg::rsp_type (image summary)
//   csr_*        in    csr_write_en           weak_tolerance, 16 bits
//
// one transaction per cycle while req_ready is high; results are registered
// stage 1 reads or writes the reference store, stage 2 compares and counts
// req_ready falls only while an end-of-image sits behind an unaccepted result
// synchronous reset clears all counters; the reference store is not cleared,
// each position is rewritten by revolution 0 before a later revolution reads it
module flux_weak_track_detector_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  fwtd_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output fwtd_pkg::rsp_type             rsp_data,
   input  logic                          csr_write_en,
   input  logic [fwtd_pkg::TOL_W-1:0]    csr_write_data
);

   logic                            advance;
   logic                            stage_valid;
   fwtd_pkg::stage_type             stage_item;
   logic [fwtd_pkg::INTERVAL_W-1:0] ref_data;

   fwtd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_item  (stage_item),
      .ref_data    (ref_data)
   );

   fwtd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .stage_valid    (stage_valid),
      .stage_item     (stage_item),
      .ref_data       (ref_data),
      .advance        (advance),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data)
   );

   // a new result only follows an end-of-image in the compare stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(stage_valid && stage_item.opcode == fwtd_pkg::OP_END_IMAGE))
      else $error("result raised without end-of-image");

   // input stalls only under a blocked result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without output backpressure");

   // summary flags agree with their counts
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == (rsp_data.track_total == 8'd0)) &&
                    (rsp_data.any_weak == (rsp_data.weak_tracks != 8'd0)))
      else $error("summary flags inconsistent");

   // weak tracks are a subset of counted tracks
   a_weak_subset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.weak_tracks <= rsp_data.track_total)
      else $error("more weak tracks than tracks");

endmodule

// ===== hdl/fwtd_ref_store.sv =====
// fwtd_ref_store: single-port store for the reference revolution intervals
// read-first, registered read data held while no read is enabled
// depends on fwtd_pkg
module fwtd_ref_store (
   input  logic                                  clock,
   input  logic [fwtd_pkg::FLUX_ADDR_W-1:0]      addr,
   input  logic                                  wr_en,
   input  logic [fwtd_pkg::INTERVAL_W-1:0]       wr_data,
   input  logic                                  rd_en,
   output logic [fwtd_pkg::INTERVAL_W-1:0]       rd_data
);

   logic [fwtd_pkg::INTERVAL_W-1:0] mem [fwtd_pkg::MAX_FLUX_PER_REV];
   logic [fwtd_pkg::INTERVAL_W-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/fwtd_front.sv =====
// fwtd_front: tracks sample position, reference length and revolution count
// drives the reference store and registers each transaction for the compare stage
// depends on fwtd_pkg and fwtd_ref_store
module fwtd_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  fwtd_pkg::req_type                  req_data,
   input  logic                               advance,
   output logic                               stage_valid,
   output fwtd_pkg::stage_type                stage_item,
   output logic [fwtd_pkg::INTERVAL_W-1:0]    ref_data
);

   logic [fwtd_pkg::COUNT_W-1:0] idx_ff, idx_in;
   logic [fwtd_pkg::COUNT_W-1:0] ref_len_ff, ref_len_in;
   logic [fwtd_pkg::REV_W-1:0]   rev_ff, rev_in;
   logic                         stage_valid_ff, stage_valid_in;
   fwtd_pkg::stage_type          stage_item_ff, stage_item_in;
   logic                         accept;
   logic                         in_cap;
   logic                         rev_nz;
   logic                         wr_en;

   assign req_ready = !stage_valid_ff || advance;
   assign accept    = req_valid && req_ready;
   assign in_cap    = idx_ff < fwtd_pkg::COUNT_W'(fwtd_pkg::MAX_FLUX_PER_REV);
   assign rev_nz    = rev_ff != '0;

   // per-transaction flags for the compare stage
   always_comb begin
      stage_item_in.opcode        = req_data.opcode;
      stage_item_in.flux_interval = req_data.flux_interval;
      stage_item_in.rev_count     = rev_ff;
      stage_item_in.rev_nonzero   = rev_nz;
      stage_item_in.sample_count  = idx_ff;
      stage_item_in.len_diff      = idx_ff != ref_len_ff;
      stage_item_in.cmp_en        = rev_nz && in_cap && (idx_ff < ref_len_ff);
      stage_item_in.over_cap      = rev_nz && !in_cap;
   end

   // revolution 0 fills the reference store
   assign wr_en = accept && (req_data.opcode == fwtd_pkg::OP_SAMPLE) && !rev_nz && in_cap;

   fwtd_ref_store u_ref_store (
      .clock   (clock),
      .addr    (idx_ff[fwtd_pkg::FLUX_ADDR_W-1:0]),
      .wr_en   (wr_en),
      .wr_data (req_data.flux_interval),
      .rd_en   (accept),
      .rd_data (ref_data)
   );

   // position and revolution bookkeeping
   always_comb begin
      idx_in     = idx_ff;
      ref_len_in = ref_len_ff;
      rev_in     = rev_ff;
      if (accept) begin
         case (req_data.opcode)
            fwtd_pkg::OP_SAMPLE: begin
               if (idx_ff != '1) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            fwtd_pkg::OP_END_REV: begin
               if (!rev_nz) begin
                  ref_len_in = idx_ff;
               end
               if (rev_ff != '1) begin
                  rev_in = rev_ff + 1'b1;
               end
               idx_in = '0;
            end
            default: begin
               idx_in     = '0;
               ref_len_in = '0;
               rev_in     = '0;
            end
         endcase
      end
   end

   // stage register occupancy
   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff         <= '0;
         ref_len_ff     <= '0;
         rev_ff         <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         idx_ff         <= idx_in;
         ref_len_ff     <= ref_len_in;
         rev_ff         <= rev_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   // payload register, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_item_ff <= stage_item_in;
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage_item  = stage_item_ff;

endmodule

// ===== hdl/fwtd_back.sv =====
// fwtd_back: interval compare, weak-track judgment, image counters and result register
// also holds the tolerance register
// depends on fwtd_pkg
module fwtd_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [fwtd_pkg::TOL_W-1:0]         csr_write_data,
   input  logic                               stage_valid,
   input  fwtd_pkg::stage_type                stage_item,
   input  logic [fwtd_pkg::INTERVAL_W-1:0]    ref_data,
   output logic                               advance,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output fwtd_pkg::rsp_type                  rsp_data
);

   logic [fwtd_pkg::TOL_W-1:0]   tol_ff;
   logic                         rev_mismatch_ff, rev_mismatch_in;
   logic                         weak_flag_ff, weak_flag_in;
   logic [7:0]                   trk_ff, trk_in;
   logic [7:0]                   max_rev_ff, max_rev_in;
   logic                         multi_ff, multi_in;
   logic [fwtd_pkg::COUNT_W-1:0] trans_ff, trans_in;
   logic [7:0]                   weak_cnt_ff, weak_cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   fwtd_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic                            do_item;
   logic                            is_image;
   logic [fwtd_pkg::INTERVAL_W-1:0] abs_diff;
   logic                            sample_bad;
   logic [fwtd_pkg::COUNT_W:0]      trans_sum;
   logic                            trk_has_rev;
   logic [7:0]                      trk_close;
   logic [7:0]                      max_close;
   logic                            multi_close;
   logic [7:0]                      weak_close;

   // stall only when an end-of-image would overwrite an unaccepted result
   assign is_image = stage_item.opcode == fwtd_pkg::OP_END_IMAGE;
   assign advance  = !(is_image && rsp_valid_ff && !rsp_ready);
   assign do_item  = stage_valid && advance;

   // absolute interval difference against the reference
   assign abs_diff   = (ref_data > stage_item.flux_interval)
                       ? ref_data - stage_item.flux_interval
                       : stage_item.flux_interval - ref_data;
   assign sample_bad = stage_item.over_cap ||
                       (stage_item.cmp_en &&
                        (abs_diff > fwtd_pkg::INTERVAL_W'(tol_ff)));

   // saturating transition sum
   assign trans_sum = {1'b0, trans_ff} + {1'b0, stage_item.sample_count};

   // track close values
   assign trk_has_rev = stage_item.rev_nonzero;
   assign trk_close   = (trk_has_rev && trk_ff != 8'hFF) ? trk_ff + 8'd1 : trk_ff;
   assign max_close   = (stage_item.rev_count > max_rev_ff) ? stage_item.rev_count
                                                            : max_rev_ff;
   assign multi_close = multi_ff || (stage_item.rev_count > 8'd1);
   assign weak_close  = (stage_item.rev_count > 8'd1 && weak_flag_ff &&
                         weak_cnt_ff != 8'hFF) ? weak_cnt_ff + 8'd1 : weak_cnt_ff;

   // per-opcode state update
   always_comb begin
      rev_mismatch_in = rev_mismatch_ff;
      weak_flag_in    = weak_flag_ff;
      trk_in          = trk_ff;
      max_rev_in      = max_rev_ff;
      multi_in        = multi_ff;
      trans_in        = trans_ff;
      weak_cnt_in     = weak_cnt_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      if (do_item) begin
         case (stage_item.opcode)
            fwtd_pkg::OP_SAMPLE: begin
               if (sample_bad) begin
                  rev_mismatch_in = 1'b1;
               end
            end
            fwtd_pkg::OP_END_REV: begin
               if (stage_item.rev_nonzero && (stage_item.len_diff || rev_mismatch_ff)) begin
                  weak_flag_in = 1'b1;
               end
               trans_in        = trans_sum[fwtd_pkg::COUNT_W] ? '1
                                 : trans_sum[fwtd_pkg::COUNT_W-1:0];
               rev_mismatch_in = 1'b0;
            end
            fwtd_pkg::OP_END_TRACK: begin
               if (trk_has_rev) begin
                  trk_in      = trk_close;
                  max_rev_in  = max_close;
                  multi_in    = multi_close;
                  weak_cnt_in = weak_close;
               end
               weak_flag_in    = 1'b0;
               rev_mismatch_in = 1'b0;
            end
            default: begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.track_total      = trk_close;
               rsp_data_in.most_revolutions = trk_has_rev ? max_close : max_rev_ff;
               rsp_data_in.multi_revolution = trk_has_rev ? multi_close : multi_ff;
               rsp_data_in.transition_total = trans_ff;
               rsp_data_in.weak_tracks      = trk_has_rev ? weak_close : weak_cnt_ff;
               rsp_data_in.any_weak         = (trk_has_rev ? weak_close : weak_cnt_ff) != 8'd0;
               rsp_data_in.status           = trk_close == 8'd0;
               rev_mismatch_in = 1'b0;
               weak_flag_in    = 1'b0;
               trk_in          = '0;
               max_rev_in      = '0;
               multi_in        = 1'b0;
               trans_in        = '0;
               weak_cnt_in     = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff          <= fwtd_pkg::DEFAULT_TOLERANCE;
         rev_mismatch_ff <= 1'b0;
         weak_flag_ff    <= 1'b0;
         trk_ff          <= '0;
         max_rev_ff      <= '0;
         multi_ff        <= 1'b0;
         trans_ff        <= '0;
         weak_cnt_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_en) begin
            tol_ff <= csr_write_data;
         end
         rev_mismatch_ff <= rev_mismatch_in;
         weak_flag_ff    <= weak_flag_in;
         trk_ff          <= trk_in;
         max_rev_ff      <= max_rev_in;
         multi_ff        <= multi_in;
         trans_ff        <= trans_in;
         weak_cnt_ff     <= weak_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result payload, no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
